// File: src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int BufferDepthDefault = 64;

  localparam int AddrW  = 8;   // slave_address_rw
  localparam int LenW   = 7;   // transfer_length, also byte position
  localparam int IdxW   = 6;   // buffer_index
  localparam int ByteW  = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [LenW-1:0] PosMax = '1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_EVENT = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    EV_START   = 4'd0,
    EV_RSTART  = 4'd1,
    EV_TX_SLA  = 4'd2,
    EV_TX_DATA = 4'd3,
    EV_RX_SLA  = 4'd4,
    EV_RX_ACK  = 4'd5,
    EV_RX_NACK = 4'd6,
    EV_ARB     = 4'd7
  } bus_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_LENGTH     = 2'd1
  } cfg_reg_e;

  // buffer port controls from the core to the memory
  typedef struct packed {
    logic we;
    logic re;
  } buf_ctl_t;

endpackage

// File: src/i2cms_if.sv
// ----------------------------------------------------------------------------
// i2cms_req_if / i2cms_rsp_if
// Valid/ready channels for sequencer requests and results.
// ----------------------------------------------------------------------------
interface i2cms_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [i2cms_pkg::IdxW-1:0]       buffer_index;
  logic [i2cms_pkg::ByteW-1:0]      write_byte;
  logic [3:0]                       bus_event;
  logic [i2cms_pkg::ByteW-1:0]      received_byte;

  modport source (output valid, opcode, buffer_index, write_byte, bus_event,
                  received_byte, input ready);
  modport sink   (input valid, opcode, buffer_index, write_byte, bus_event,
                  received_byte, output ready);
endinterface

interface i2cms_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             send_start;
  logic                             send_stop;
  logic                             ack_next;
  logic                             drive_valid;
  logic [i2cms_pkg::ByteW-1:0]      drive_byte;
  logic                             busy_res;
  logic [i2cms_pkg::ByteW-1:0]      read_byte;

  modport source (output valid, send_start, send_stop, ack_next, drive_valid,
                  drive_byte, busy_res, read_byte, input ready);
  modport sink   (input valid, send_start, send_stop, ack_next, drive_valid,
                  drive_byte, busy_res, read_byte, output ready);
endinterface

// File: src/i2cms_buf.sv
// ----------------------------------------------------------------------------
// i2cms_buf
// Byte buffer: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module i2cms_buf #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BufferDepthDefault,
  parameter int AW           = 6
) (
  input  logic                        clk_i,
  input  i2cms_pkg::buf_ctl_t         ctl_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [i2cms_pkg::ByteW-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [i2cms_pkg::ByteW-1:0] rdata_o
);
  import i2cms_pkg::*;

  logic [ByteW-1:0] mem [BUFFER_DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/i2cms_core.sv
// ----------------------------------------------------------------------------
// i2cms_core
// Config registers, transfer state, item decode and result register.
// ----------------------------------------------------------------------------
module i2cms_core #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BufferDepthDefault,
  parameter int AW           = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cms_pkg::CfgDataW-1:0] cfg_data_i,
  i2cms_req_if.sink                      req,
  i2cms_rsp_if.source                    rsp,
  output i2cms_pkg::buf_ctl_t            buf_ctl_o,
  output logic [AW-1:0]                  buf_waddr_o,
  output logic [i2cms_pkg::ByteW-1:0]    buf_wdata_o,
  output logic [AW-1:0]                  buf_raddr_o,
  input  logic [i2cms_pkg::ByteW-1:0]    buf_rdata_i
);
  import i2cms_pkg::*;

  logic [AddrW-1:0] slave_addr_q;
  logic [LenW-1:0]  length_q;
  logic [LenW-1:0]  pos_q, pos_d;
  logic             busy_q, busy_d;

  logic             acc;
  logic             idx_ok, pos_ok;

  logic             start_d, stop_d, ack_d, dvalid_d, rd_mem_d, drv_mem_d;
  logic [ByteW-1:0] dbyte_d;

  logic             rsp_valid_q;
  logic             start_q, stop_q, ack_q, dvalid_q, rd_mem_q, drv_mem_q, busy_res_q;
  logic [ByteW-1:0] dbyte_q;

  buf_ctl_t         ctl;

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign acc       = req.valid && req.ready;

  assign idx_ok = 32'(req.buffer_index) < 32'(BUFFER_DEPTH);
  assign pos_ok = 32'(pos_q) < 32'(BUFFER_DEPTH);

  always_comb begin
    pos_d     = pos_q;
    busy_d    = busy_q;
    start_d   = 1'b0;
    stop_d    = 1'b0;
    ack_d     = 1'b0;
    dvalid_d  = 1'b0;
    dbyte_d   = '0;
    rd_mem_d  = 1'b0;
    drv_mem_d = 1'b0;
    ctl       = '0;
    buf_waddr_o = AW'(req.buffer_index);
    buf_wdata_o = req.write_byte;
    buf_raddr_o = AW'(req.buffer_index);
    case (req.opcode)
      OP_LOAD: begin
        ctl.we = idx_ok;
      end
      OP_READ: begin
        ctl.re   = 1'b1;
        rd_mem_d = idx_ok;
      end
      OP_START: begin
        if (!busy_q) begin
          busy_d  = 1'b1;
          start_d = 1'b1;
        end
      end
      default: begin
        // bus status event, only handled while a transfer runs
        if (busy_q) begin
          case (req.bus_event)
            EV_START, EV_RSTART: begin
              pos_d    = '0;
              dvalid_d = 1'b1;
              dbyte_d  = slave_addr_q;
            end
            EV_TX_SLA, EV_TX_DATA: begin
              if (pos_q < length_q) begin
                dvalid_d    = 1'b1;
                drv_mem_d   = pos_ok;
                ctl.re      = 1'b1;
                buf_raddr_o = AW'(pos_q);
                pos_d       = pos_q + 1'b1;
              end else begin
                stop_d = 1'b1;
                busy_d = 1'b0;
              end
            end
            EV_RX_SLA, EV_RX_ACK: begin
              if (req.bus_event == EV_RX_ACK) begin
                ctl.we      = pos_ok;
                buf_waddr_o = AW'(pos_q);
                buf_wdata_o = req.received_byte;
                pos_d       = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
              end
              // ack all but the last byte; length zero wraps and always acks
              ack_d = (length_q == '0) ||
                      (({1'b0, pos_d} + 8'd1) < {1'b0, length_q});
            end
            EV_RX_NACK: begin
              ctl.we      = pos_ok;
              buf_waddr_o = AW'(pos_q);
              buf_wdata_o = req.received_byte;
              pos_d       = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
              stop_d      = 1'b1;
              busy_d      = 1'b0;
            end
            EV_ARB: begin
              start_d = 1'b1;
            end
            default: begin
              stop_d = 1'b1;
              busy_d = 1'b0;
            end
          endcase
        end
      end
    endcase
    ctl.we = ctl.we && acc;
    ctl.re = ctl.re && acc;
  end

  assign buf_ctl_o = ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= '0;
      length_q     <= '0;
      pos_q        <= '0;
      busy_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLAVE_ADDR: slave_addr_q <= cfg_data_i;
          CFG_LENGTH:     length_q     <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        pos_q  <= pos_d;
        busy_q <= busy_d;
      end
      if (req.ready) begin
        rsp_valid_q <= req.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      start_q    <= start_d;
      stop_q     <= stop_d;
      ack_q      <= ack_d;
      dvalid_q   <= dvalid_d;
      dbyte_q    <= dbyte_d;
      busy_res_q <= busy_d;
      rd_mem_q   <= rd_mem_d;
      drv_mem_q  <= drv_mem_d;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.send_start  = start_q;
  assign rsp.send_stop   = stop_q;
  assign rsp.ack_next    = ack_q;
  assign rsp.drive_valid = dvalid_q;
  assign rsp.drive_byte  = drv_mem_q ? buf_rdata_i : dbyte_q;
  assign rsp.busy_res    = busy_res_q;
  assign rsp.read_byte   = rd_mem_q ? buf_rdata_i : '0;

  // busy only rises on an accepted start request
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(acc && req.opcode == OP_START))
    else $error("busy set without start request");

  // position only moves on an accepted item
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(pos_q))
    else $error("byte position moved without a transfer");

  // a result never asks for start and stop together
  a_start_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(start_q && stop_q))
    else $error("start and stop requested together");

  // the buffer is never read and written by the same item
  a_buf_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.we && ctl.re))
    else $error("buffer read and write in one item");

endmodule

// File: src/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Latency: a result is valid the cycle after its request transfer.
// Throughput: one request per cycle; the result register refills while its
//   current result is taken, so only a stalled result holds back new requests.
// Reset: rst_ni clears config, position, busy and the result valid; the byte
//   buffer is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// Sequences one I2C master transaction from bus status events. Requests load
// or read a buffer byte, start a transfer, or report a bus event; each one
// yields exactly one result.
//
// Structure:
//   i2cms_core  - config registers, byte position and busy flag, request
//                 decode and the result register.
//   i2cms_buf   - byte buffer memory, registered read. A transmit event reads
//                 the byte at the current position in the request cycle and
//                 the data lands together with the result register.
// Each request uses at most one buffer access, so one write and one read
// port suffice and a write is visible to the very next request.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BufferDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cms_pkg::CfgDataW-1:0] cfg_data_i,
  i2cms_req_if.sink                      req_i,
  i2cms_rsp_if.source                    rsp_o
);
  import i2cms_pkg::*;

  // buffer address width, at least one bit
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  buf_ctl_t         buf_ctl;
  logic [AW-1:0]    buf_waddr;
  logic [AW-1:0]    buf_raddr;
  logic [ByteW-1:0] buf_wdata;
  logic [ByteW-1:0] buf_rdata;

  i2cms_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .buf_ctl_o   (buf_ctl),
    .buf_waddr_o (buf_waddr),
    .buf_wdata_o (buf_wdata),
    .buf_raddr_o (buf_raddr),
    .buf_rdata_i (buf_rdata)
  );

  i2cms_buf #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_buf (
    .clk_i   (clk_i),
    .ctl_i   (buf_ctl),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

endmodule
